[hw/rtl/hbkd_pkg.sv]
// Package for the boot keyboard report differ: item types, queue job type,
// usage and modifier keycode tables. No dependencies.
package hbkd_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int MOD_EVENTS = 6;
    localparam int EV_N = MOD_EVENTS + 2 * KEY_SLOTS;
    localparam int EV_W = $clog2(EV_N);
    localparam int Q_DEPTH = 2;
    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam int MAP_SIZE = 100;
    localparam logic [7:0] NO_KEY_LIMIT = 8'h04;

    typedef logic [6:0] key_code_t;
    typedef logic [7:0] usage_t;

    typedef struct packed {
        logic [7:0] mod_bits;
        logic [7:0] usage_0;
        logic [7:0] usage_1;
        logic [7:0] usage_2;
        logic [7:0] usage_3;
        logic [7:0] usage_4;
        logic [7:0] usage_5;
    } rpt_item_t;

    typedef struct packed {
        logic [6:0] key_code;
        logic       is_press;
        logic       last_event;
    } evt_item_t;

    typedef struct packed {
        logic [EV_N-1:0]            mask;
        logic [EV_N-1:0]            press;
        logic [EV_N-1:0][6:0]       code;
    } job_t;

    localparam key_code_t USAGE_MAP [0:MAP_SIZE-1] = '{
        7'd0, 7'd0, 7'd0, 7'd0,
        7'd30, 7'd48, 7'd46, 7'd32, 7'd18, 7'd33, 7'd34, 7'd35, 7'd23, 7'd36, 7'd37,
        7'd38, 7'd50,
        7'd49, 7'd24, 7'd25, 7'd16, 7'd19, 7'd31, 7'd20, 7'd22, 7'd47, 7'd17, 7'd45,
        7'd21, 7'd44,
        7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10, 7'd11,
        7'd28, 7'd1, 7'd14, 7'd15, 7'd57, 7'd12, 7'd13, 7'd26, 7'd27, 7'd43, 7'd0,
        7'd39, 7'd40, 7'd41, 7'd51, 7'd52, 7'd53,
        7'd58,
        7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd87,
        7'd88,
        7'd99, 7'd70, 7'd119,
        7'd110, 7'd102, 7'd104, 7'd111, 7'd107, 7'd109, 7'd106, 7'd105, 7'd108,
        7'd103,
        7'd69, 7'd98, 7'd55, 7'd74, 7'd78, 7'd96, 7'd79, 7'd80, 7'd81, 7'd75, 7'd76,
        7'd77, 7'd71, 7'd72, 7'd73, 7'd82, 7'd83
    };

    // Modifier bits that raise events: left ctrl, shift, alt, right ctrl, shift, alt.
    localparam logic [2:0] MOD_BIT [0:MOD_EVENTS-1] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6};
    localparam key_code_t MOD_CODE [0:MOD_EVENTS-1] = '{
        7'd29, 7'd42, 7'd56, 7'd97, 7'd54, 7'd100
    };

    function automatic key_code_t map_usage(input usage_t u);
        key_code_t r;
        r = '0;
        if (u < 8'(MAP_SIZE))
            r = USAGE_MAP[u[6:0]];
        return r;
    endfunction

endpackage

[hw/rtl/hid_boot_keyboard_report_diff.sv]
// Top level of the boot keyboard report differ: front end, job queue, back end.
// Depends on hbkd_pkg, hbkd_front, hbkd_queue, hbkd_back.
//
//   channel | handshake            | payload
//   report  | rpt_valid, rpt_stall | rpt (rpt_item_t)
//   events  | evt_valid, evt_stall | evt (evt_item_t)
//
// A report is taken every cycle while the two-entry job queue has room.
// Unless evt_stall holds it, the back end sends one event per cycle, 0 to 18
// per report; a job passes the queue, back-end registers and event register.
// Reset clears the stored report to zero and empties queue and output.
// Output stall holds the event register and backs up through the queue.
module hid_boot_keyboard_report_diff
    import hbkd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rpt_valid,
    output logic      rpt_stall,
    input  rpt_item_t rpt,
    output logic      evt_valid,
    input  logic      evt_stall,
    output evt_item_t evt
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    job_t q_job_in;
    job_t q_job_out;

    hbkd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rpt_valid (rpt_valid),
        .rpt_stall (rpt_stall),
        .rpt       (rpt),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job_in)
    );

    hbkd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_job_out)
    );

    hbkd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_job   (q_job_out),
        .pop        (q_pop),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queue overflow");

    a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (evt.key_code != '0))
        else $error("event with zero key code");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_stall && !evt.last_event) |=> evt_valid)
        else $error("event burst broken before last event");

endmodule

[hw/rtl/hbkd_front.sv]
// Front end: accepts reports, diffs them against the stored report and
// builds one event job per report that changes anything. Depends on hbkd_pkg.
module hbkd_front
    import hbkd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rpt_valid,
    output logic      rpt_stall,
    input  rpt_item_t rpt,
    input  logic      q_full,
    output logic      q_push,
    output job_t      q_job
);

    logic [7:0] old_mods_reg;
    logic [7:0] old_mods_next;
    usage_t     old_usages_reg [KEY_SLOTS];
    usage_t     old_usages_next [KEY_SLOTS];
    usage_t     cur [KEY_SLOTS];
    logic [7:0] diff;
    logic       take;

    always_comb
    begin
        cur[0] = rpt.usage_0;
        cur[1] = rpt.usage_1;
        cur[2] = rpt.usage_2;
        cur[3] = rpt.usage_3;
        cur[4] = rpt.usage_4;
        cur[5] = rpt.usage_5;
    end

    assign rpt_stall = q_full;
    assign take = rpt_valid && !q_full;
    assign diff = rpt.mod_bits ^ old_mods_reg;

    always_comb
    begin
        logic held;
        key_code_t kc;
        q_job = '0;
        for (int m = 0; m < MOD_EVENTS; m++)
        begin
            q_job.mask[m]  = diff[MOD_BIT[m]];
            q_job.press[m] = rpt.mod_bits[MOD_BIT[m]];
            q_job.code[m]  = MOD_CODE[m];
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            held = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
                if (cur[j] == old_usages_reg[i])
                    held = 1'b1;
            kc = map_usage(old_usages_reg[i]);
            q_job.mask[MOD_EVENTS + i]  = (old_usages_reg[i] >= NO_KEY_LIMIT) && !held
                                          && (kc != '0);
            q_job.press[MOD_EVENTS + i] = 1'b0;
            q_job.code[MOD_EVENTS + i]  = kc;
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            held = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
                if (old_usages_reg[j] == cur[i])
                    held = 1'b1;
            kc = map_usage(cur[i]);
            q_job.mask[MOD_EVENTS + KEY_SLOTS + i]  = (cur[i] >= NO_KEY_LIMIT) && !held
                                                      && (kc != '0);
            q_job.press[MOD_EVENTS + KEY_SLOTS + i] = 1'b1;
            q_job.code[MOD_EVENTS + KEY_SLOTS + i]  = kc;
        end
    end

    // Drop reports that change nothing visible.
    assign q_push = take && (q_job.mask != '0);

    always_comb
    begin
        old_mods_next = old_mods_reg;
        old_usages_next = old_usages_reg;
        if (take)
        begin
            old_mods_next = rpt.mod_bits;
            old_usages_next = cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_mods_reg <= '0;
            for (int i = 0; i < KEY_SLOTS; i++)
                old_usages_reg[i] <= '0;
        end
        else
        begin
            old_mods_reg <= old_mods_next;
            old_usages_reg <= old_usages_next;
        end
    end

endmodule

[hw/rtl/hbkd_queue.sv]
// Two-entry job queue between front and back ends.
// Depends on hbkd_pkg.
module hbkd_queue
    import hbkd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_AW:0]   count_reg;
    logic [Q_AW:0]   count_next;
    logic            do_pop;

    assign full = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job = mem[rd_ptr_reg];
    assign do_pop = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/hbkd_back.sv]
// Back end: walks the pending events of one job, lowest first, into a
// registered output item. Depends on hbkd_pkg.
module hbkd_back
    import hbkd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    output logic      evt_valid,
    input  logic      evt_stall,
    output evt_item_t evt
);

    logic [EV_N-1:0]      mask_reg;
    logic [EV_N-1:0]      mask_next;
    logic [EV_N-1:0]      press_reg;
    logic [EV_N-1:0]      press_next;
    logic [EV_N-1:0][6:0] code_reg;
    logic [EV_N-1:0][6:0] code_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    evt_item_t            out_reg;
    evt_item_t            out_next;
    logic [EV_W-1:0]      sel;
    logic [EV_N-1:0]      mask_clr;
    logic                 emit;

    always_comb
    begin
        sel = '0;
        for (int i = EV_N - 1; i >= 0; i--)
            if (mask_reg[i])
                sel = EV_W'(i);
    end

    always_comb
    begin
        emit = (mask_reg != '0) && (!out_valid_reg || !evt_stall);
        mask_clr = mask_reg;
        if (emit)
            mask_clr[sel] = 1'b0;
        pop = head_valid && (mask_clr == '0);

        mask_next = mask_clr;
        press_next = press_reg;
        code_next = code_reg;
        if (pop)
        begin
            mask_next = head_job.mask;
            press_next = head_job.press;
            code_next = head_job.code;
        end

        out_next = out_reg;
        out_valid_next = out_valid_reg && evt_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next.key_code = code_reg[sel];
            out_next.is_press = press_reg[sel];
            out_next.last_event = (mask_clr == '0);
        end
    end

    assign evt_valid = out_valid_reg;
    assign evt = out_reg;

    always_ff @(posedge clk)
    begin
        press_reg <= press_next;
        code_reg <= code_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
